// ===== design/lafortune_brdf_evaluator_assert.svh =====
// Assertion macros for the checker of the BRDF evaluator.
// Each macro expects signals clk and rst_n in the scope where it is used.
`ifndef LAFORTUNE_BRDF_EVALUATOR_ASSERT_SVH
`define LAFORTUNE_BRDF_EVALUATOR_ASSERT_SVH

// Same-cycle implication.
`define LBE_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lbe checker: same-cycle rule violated");

// Next-cycle implication.
`define LBE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lbe checker: next-cycle rule violated");

`endif

// ===== design/lbe_pkg.sv =====
// Package for the Lafortune BRDF evaluator: formats, constants, register codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package lbe_pkg;

    localparam int NUM_LOBES_DEF = 3;
    localparam int LOBE_REGS     = 3;
    localparam int COMP_W        = 16;
    localparam int CFG_W         = 64;
    localparam int CFG_IDX_W     = 3;
    localparam int OUT_W         = 24;
    localparam int NORM_W        = 24;
    localparam int POW_W         = 17;
    localparam int SQ_STEPS      = 14;
    localparam logic [14:0] ONE_Q14 = 15'd16384;
    localparam logic [NORM_W-1:0] NORM_RESET = 24'd65536;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOBE0,
        REG_LOBE1,
        REG_LOBE2,
        REG_DIFFUSE,
        REG_NDOTL,
        REG_LOBE_SCALE,
        REG_NORM
    } cfg_reg_t;

endpackage
`default_nettype wire

// ===== design/lafortune_brdf_evaluator.sv =====
// Top level of the three-lobe Lafortune BRDF evaluator, a 29-stage pipeline.
// Depends on lbe_pkg.
//
// Channel   Direction  Word
// s_*       in         tdata: light_x, light_y, light_z, view_x, view_y, view_z; tlast: last_dir
// m_*       out        tdata: brdf_value; tlast: last_out
// cfg_*     in         register index and data, written when cfg_we is high
//
// One word enters per cycle unless the output word is held.
// Fourteen of the stages hold the squaring multipliers of the log2 step, one per stage.
// Reset clears the valid bits and the registers; payload flops are not reset.
// When the output word is held, the whole pipeline holds and s_tready falls.
`timescale 1ns / 1ps
`default_nettype none
module lafortune_brdf_evaluator
    import lbe_pkg::*;
#(
    parameter int NUM_LOBES = NUM_LOBES_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [95:0]          s_tdata,   // light_x, light_y, light_z, view_x, view_y, view_z
    input  wire logic                 s_tlast,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [OUT_W-1:0]          m_tdata,   // brdf_value
    output logic                      m_tlast,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    localparam int LANES = (NUM_LOBES < LOBE_REGS) ? NUM_LOBES : LOBE_REGS;
    localparam int SUM_W = POW_W + $clog2(LANES);
    localparam int NSTG  = 29;

    // Configuration registers.
    logic [CFG_W-1:0]  lobe_reg [LOBE_REGS];
    logic signed [15:0] diffuse_reg;
    logic signed [15:0] ndotl_reg;
    logic signed [15:0] lscale_reg;
    logic [NORM_W-1:0] norm_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LOBE_REGS; i++)
            begin
                lobe_reg[i] <= '0;
            end
            diffuse_reg <= '0;
            ndotl_reg   <= '0;
            lscale_reg  <= '0;
            norm_reg    <= NORM_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_LOBE0:      lobe_reg[0] <= cfg_data;
                REG_LOBE1:      lobe_reg[1] <= cfg_data;
                REG_LOBE2:      lobe_reg[2] <= cfg_data;
                REG_DIFFUSE:    diffuse_reg <= cfg_data[15:0];
                REG_NDOTL:      ndotl_reg   <= cfg_data[15:0];
                REG_LOBE_SCALE: lscale_reg  <= cfg_data[15:0];
                REG_NORM:       norm_reg    <= cfg_data[NORM_W-1:0];
                default:        ;
            endcase
        end
    end

    // Pipeline control.
    logic [NSTG-1:0] vld_reg;
    logic            adv;

    assign adv      = m_tready | ~vld_reg[NSTG-1];
    assign s_tready = adv;
    assign m_tvalid = vld_reg[NSTG-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NSTG-2:0], s_tvalid};
        end
    end

    // Side channels.
    logic [14:0] nl_pipe_reg [25];
    logic        last_pipe_reg [NSTG];

    // Stage 1: lateral products and clamped normal dots.
    logic signed [31:0] px_reg, pz_reg;
    logic [14:0]        nv_reg;
    logic signed [31:0] px_next, pz_next;
    logic [14:0]        nl_next, nv_next;

    always_comb
    begin
        logic signed [15:0] lx, ly, lz, vx, vy, vz;
        lx = s_tdata[15:0];
        ly = s_tdata[31:16];
        lz = s_tdata[47:32];
        vx = s_tdata[63:48];
        vy = s_tdata[79:64];
        vz = s_tdata[95:80];
        px_next = lx * vx;
        pz_next = lz * vz;
        if (ly < 0)
            nl_next = '0;
        else if (ly > 16'sd16384)
            nl_next = ONE_Q14;
        else
            nl_next = ly[14:0];
        if (vy < 0)
            nv_next = '0;
        else if (vy > 16'sd16384)
            nv_next = ONE_Q14;
        else
            nv_next = vy[14:0];
    end

    // Stage 2: lateral dot in Q14 and the normal product.
    logic signed [15:0] lat2_reg;
    logic [14:0]        nrm2_reg;
    logic signed [15:0] lat2_next;
    logic [14:0]        nrm2_next;

    always_comb
    begin
        logic signed [32:0] dsum;
        logic signed [32:0] dcl;
        logic signed [32:0] dsh;
        logic [29:0]        nn;
        dsum = {px_reg[31], px_reg} + {pz_reg[31], pz_reg};
        if (dsum > 33'sd268435456)
            dcl = 33'sd268435456;
        else if (dsum < -33'sd268435456)
            dcl = -33'sd268435456;
        else
            dcl = dsum;
        dsh       = dcl >>> 14;
        lat2_next = dsh[15:0];
        nn        = nl_pipe_reg[0] * nv_reg;
        nrm2_next = nn[28:14];
    end

    // Stage 3: mid term.
    logic signed [15:0] lat3_reg;
    logic [14:0]        nrm3_reg, mid3_reg;
    logic [14:0]        mid3_next;

    always_comb
    begin
        logic [14:0] alat;
        logic [15:0] msum;
        alat = (lat2_reg < 0) ? 15'(-lat2_reg) : lat2_reg[14:0];
        msum = {1'b0, alat} + {1'b0, nrm2_reg};
        mid3_next = (msum > {1'b0, ONE_Q14}) ? ONE_Q14 : msum[14:0];
    end

    logic [POW_W-1:0] pow_reg [LANES];

    // Per-lobe lanes: stages 4 to 24.
    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        logic signed [31:0] pa_reg, pb_reg, pc_reg;
        logic [14:0]        x_reg;
        logic [14:0]        m_reg [SQ_STEPS+1];
        logic [13:0]        f_reg [SQ_STEPS+1];
        logic [3:0]         d_reg [SQ_STEPS+1];
        logic               z_reg [18];
        logic [25:0]        e_reg;
        logic [27:0]        rr_reg;
        logic [13:0]        lin_reg;
        logic [3:0]         k22_reg, k23_reg;
        logic               big22_reg, big23_reg;
        logic [POW_W-1:0]   poly_reg;

        logic signed [31:0] pa_next, pb_next, pc_next;
        logic [14:0]        x_next;
        logic [14:0]        m0_next;
        logic [3:0]         d0_next;
        logic [25:0]        e_next;
        logic [27:0]        rr_next;
        logic [13:0]        lin_next;
        logic [3:0]         k_next;
        logic               big_next;
        logic [POW_W-1:0]   poly_next, pow_next;
        logic [15:0]        expo;

        assign expo = lobe_reg[g][63:48];

        always_comb
        begin
            logic signed [15:0] cx, cy, cz, om, nr;
            cx = lobe_reg[g][15:0];
            cy = lobe_reg[g][31:16];
            cz = lobe_reg[g][47:32];
            om = {1'b0, ONE_Q14 - mid3_reg};
            nr = {1'b0, nrm3_reg};
            pa_next = cx * lat3_reg;
            pb_next = cy * om;
            pc_next = cz * nr;
        end

        always_comb
        begin
            logic signed [33:0] ls;
            ls = {{2{pa_reg[31]}}, pa_reg} + {{2{pb_reg[31]}}, pb_reg}
               + {{2{pc_reg[31]}}, pc_reg};
            if (ls < 0)
                x_next = '0;
            else if (ls > 34'sd134217728)
                x_next = ONE_Q14;
            else
                x_next = ls[27:13];
        end

        always_comb
        begin
            logic [3:0] p;
            p = '0;
            for (int i = 0; i < 15; i++)
            begin
                if (x_reg[i])
                    p = 4'(i);
            end
            d0_next = 4'd14 - p;
            m0_next = x_reg << d0_next;
        end

        always_comb
        begin
            logic [17:0] base;
            logic [33:0] prod;
            base   = {d_reg[SQ_STEPS], 14'b0} - {4'b0, f_reg[SQ_STEPS]};
            prod   = base * expo;
            e_next = prod[33:8];
        end

        always_comb
        begin
            logic [11:0] kk;
            logic [13:0] r;
            logic [27:0] lp;
            kk       = e_reg[25:14];
            r        = e_reg[13:0];
            big_next = (kk >= 12'd15);
            k_next   = kk[3:0];
            rr_next  = r * r;
            lp       = 14'd10756 * r;
            lin_next = lp[27:14];
        end

        always_comb
        begin
            logic [39:0] qp;
            qp        = 12'd2564 * rr_reg;
            poly_next = POW_W'(ONE_Q14) - POW_W'(lin_reg) + POW_W'(qp[39:28]);
        end

        always_comb
        begin
            if (z_reg[17])
                pow_next = (expo == '0) ? POW_W'(ONE_Q14) : '0;
            else if (big23_reg)
                pow_next = '0;
            else
                pow_next = poly_reg >> k23_reg;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                pa_reg    <= pa_next;
                pb_reg    <= pb_next;
                pc_reg    <= pc_next;
                x_reg     <= x_next;
                m_reg[0]  <= m0_next;
                f_reg[0]  <= '0;
                d_reg[0]  <= d0_next;
                z_reg[0]  <= (x_reg == '0);
                for (int j = 1; j < 18; j++)
                begin
                    z_reg[j] <= z_reg[j-1];
                end
                e_reg     <= e_next;
                rr_reg    <= rr_next;
                lin_reg   <= lin_next;
                k22_reg   <= k_next;
                big22_reg <= big_next;
                k23_reg   <= k22_reg;
                big23_reg <= big22_reg;
                poly_reg  <= poly_next;
                pow_reg[g] <= pow_next;
            end
        end

        // Squaring steps of the log2 fraction, one bit per stage.
        for (genvar s = 1; s <= SQ_STEPS; s++)
        begin : g_sq
            logic [29:0] sq;
            logic [14:0] mn;
            logic        fb;

            always_comb
            begin
                sq = m_reg[s-1] * m_reg[s-1];
                fb = sq[29];
                mn = fb ? sq[29:15] : sq[28:14];
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    m_reg[s] <= mn;
                    f_reg[s] <= {f_reg[s-1][12:0], fb};
                    d_reg[s] <= d_reg[s-1];
                end
            end
        end
    end

    // Stage 25: lobe sum and N.L attenuation.
    logic [SUM_W-1:0]   lsum_reg;
    logic signed [32:0] att_reg;
    logic [SUM_W-1:0]   lsum_next;
    logic signed [32:0] att_next;

    always_comb
    begin
        logic signed [15:0] nlm;
        logic signed [31:0] ap;
        lsum_next = '0;
        for (int i = 0; i < LANES; i++)
        begin
            lsum_next = lsum_next + SUM_W'(pow_reg[i]);
        end
        nlm      = {1'b0, nl_pipe_reg[23]} - 16'sd16384;
        ap       = ndotl_reg * nlm;
        att_next = 33'sd67108864 + {ap[31], ap};
    end

    // Stage 26: lobe weight and diffuse term.
    logic signed [24:0] t_reg;
    logic signed [33:0] dterm_reg;
    logic [SUM_W-1:0]   lsum26_reg;
    logic signed [24:0] t_next;
    logic signed [33:0] dterm_next;

    always_comb
    begin
        logic signed [48:0] tp;
        logic signed [15:0] nls;
        logic signed [31:0] dp;
        tp         = att_reg * lscale_reg;
        t_next     = tp[48:24];
        nls        = {1'b0, nl_pipe_reg[24]};
        dp         = nls * diffuse_reg;
        dterm_next = {dp, 2'b00};
    end

    // Stage 27: combined sum in Q28.
    logic signed [45:0] s_reg;
    logic signed [45:0] s_next;

    always_comb
    begin
        logic signed [19:0] lss;
        logic signed [44:0] sp;
        lss    = 20'(lsum26_reg);
        sp     = t_reg * lss;
        s_next = {{12{dterm_reg[33]}}, dterm_reg} + {sp[44], sp};
    end

    // Stage 28: norm scale as two partial products.
    logic signed [50:0] ph_reg;
    logic signed [45:0] pl_reg;
    logic signed [50:0] ph_next;
    logic signed [45:0] pl_next;

    always_comb
    begin
        logic signed [25:0] sh;
        logic signed [20:0] sl;
        logic signed [24:0] ns;
        sh      = s_reg[45:20];
        sl      = {1'b0, s_reg[19:0]};
        ns      = {1'b0, norm_reg};
        ph_next = sh * ns;
        pl_next = sl * ns;
    end

    // Stage 29: final shift and saturation.
    logic [OUT_W-1:0] out_reg;
    logic [OUT_W-1:0] out_next;

    always_comb
    begin
        logic signed [70:0] tot;
        logic signed [42:0] v;
        tot = {ph_reg, 20'b0} + {{25{pl_reg[45]}}, pl_reg};
        v   = tot[70:28];
        if (v > 43'sd8388607)
            out_next = 24'h7FFFFF;
        else if (v < -43'sd8388608)
            out_next = 24'h800000;
        else
            out_next = v[OUT_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            px_reg         <= px_next;
            pz_reg         <= pz_next;
            nv_reg         <= nv_next;
            nl_pipe_reg[0] <= nl_next;
            for (int i = 1; i < 25; i++)
            begin
                nl_pipe_reg[i] <= nl_pipe_reg[i-1];
            end
            last_pipe_reg[0] <= s_tlast;
            for (int i = 1; i < NSTG; i++)
            begin
                last_pipe_reg[i] <= last_pipe_reg[i-1];
            end
            lat2_reg   <= lat2_next;
            nrm2_reg   <= nrm2_next;
            lat3_reg   <= lat2_reg;
            nrm3_reg   <= nrm2_reg;
            mid3_reg   <= mid3_next;
            lsum_reg   <= lsum_next;
            att_reg    <= att_next;
            t_reg      <= t_next;
            dterm_reg  <= dterm_next;
            lsum26_reg <= lsum_reg;
            s_reg      <= s_next;
            ph_reg     <= ph_next;
            pl_reg     <= pl_next;
            out_reg    <= out_next;
        end
    end

    assign m_tdata = out_reg;
    assign m_tlast = last_pipe_reg[NSTG-1];

endmodule
`default_nettype wire

// ===== design/lbe_checker.sv =====
// Port-level checker for the BRDF evaluator, attached by bind.
// Depends on lbe_pkg and lafortune_brdf_evaluator_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "lafortune_brdf_evaluator_assert.svh"
module lbe_checker
    import lbe_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             s_tready,
    input wire logic             m_tvalid,
    input wire logic             m_tready,
    input wire logic [OUT_W-1:0] m_tdata,
    input wire logic             m_tlast
);

    `LBE_ASSERT_NOW(a_ready_follows_sink, m_tready, s_tready)
    `LBE_ASSERT_NOW(a_stall_only_on_held_word, !s_tready, m_tvalid && !m_tready)
    `LBE_ASSERT_NEXT(a_valid_holds, m_tvalid && !m_tready, m_tvalid)
    `LBE_ASSERT_NEXT(a_word_holds, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tlast))

endmodule

bind lafortune_brdf_evaluator lbe_checker u_lbe_checker (.*);
`default_nettype wire
